/* sv/sacl_pkg.sv */
`default_nettype none

package sacl_pkg;

   // Cache geometry. All three are powers of two.
   localparam int NUM_SETS   = 8;
   localparam int WAYS       = 4;
   localparam int LINE_BYTES = 128;

   localparam int ADDR_BITS     = 32;
   localparam int COUNT_BITS    = 32;
   localparam int WAY_PORT_BITS = 2;

   localparam int OFFSET_BITS  = $clog2(LINE_BYTES);
   localparam int SET_BITS     = $clog2(NUM_SETS);
   localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_BITS     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - SET_BITS;

   typedef logic [ADDR_BITS-1:0]               addr_type;
   typedef logic [TAG_BITS-1:0]                tag_type;
   typedef logic [SET_IDX_BITS-1:0]            set_type;
   typedef logic [WAY_BITS-1:0]                way_type;
   typedef logic [WAYS-1:0]                    way_mask_type;
   typedef logic [WAYS-1:0][TAG_BITS-1:0]      tag_row_type;
   typedef logic [COUNT_BITS-1:0]              count_type;

   // Result of comparing one set against a tag.
   typedef struct packed {
      logic    hit;
      way_type way;
   } match_type;

   function automatic set_type addr_set(addr_type addr);
      addr_type line_no;
      line_no = addr >> OFFSET_BITS;
      return set_type'(line_no % NUM_SETS);
   endfunction

   function automatic tag_type addr_tag(addr_type addr);
      return tag_type'(addr >> (OFFSET_BITS + SET_BITS));
   endfunction

endpackage

`default_nettype wire

/* sv/sacl_match.sv */
`default_nettype none

module sacl_match (
   input  sacl_pkg::tag_row_type  row,
   input  sacl_pkg::way_mask_type valid,
   input  sacl_pkg::tag_type      tag,
   output sacl_pkg::match_type    match
);
   import sacl_pkg::*;

   // Parallel compare; lowest matching way wins.
   always_comb begin
      match.hit = 1'b0;
      match.way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (valid[w] && (row[w] == tag)) begin
            match.hit = 1'b1;
            match.way = way_type'(w);
         end
      end
   end

endmodule

`default_nettype wire

/* sv/set_assoc_cache_tag_lookup.sv */
`default_nettype none

// Tag store of a set-associative cache with round-robin replacement. Each
// request transaction carries a byte address; the block splits it into line
// offset (ignored), set index and tag, compares all ways of the set and
// returns one response transaction: hit flag, the matching way (or the way
// just filled on a miss) and saturating access and hit counts including this
// transaction. Tags live in a synchronous memory with one row per set (all
// ways side by side), read when the request is taken; valid bits and the
// per-set victim pointers sit in flip-flops that reset clears, so there is
// no clearing pass after reset and the block is ready at once. A request
// goes through the tag memory read, then compare and write-back, before the
// response register; the next request is accepted in the compare cycle,
// so the block sustains one transaction per cycle while responses are taken.
// A miss written back in the same cycle as a read of the same set is
// forwarded from the write-back row. Stalls on the response side hold the
// compare stage and then the request side.
module set_assoc_cache_tag_lookup (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  sacl_pkg::addr_type   req_address,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic                 rsp_hit,
   output logic [1:0]           rsp_way,
   output sacl_pkg::count_type  rsp_accesses,
   output sacl_pkg::count_type  rsp_hits
);
   import sacl_pkg::*;

   // Tag memory: one row of WAYS tags per set, contents undefined at reset.
   tag_row_type tag_mem [NUM_SETS];

   // Per-line valid bits and per-set round-robin pointers.
   logic [NUM_SETS-1:0][WAYS-1:0]     valid_ff, valid_in;
   logic [NUM_SETS-1:0][WAY_BITS-1:0] victim_ff, victim_in;

   // Compare stage.
   logic        lookup_ff, lookup_in;
   set_type     set_ff;
   tag_type     tag_ff;
   tag_row_type rdata_ff;
   logic        fwd_ff, fwd_in;
   tag_row_type fwd_row_ff;

   // Counters, also the count fields of the response.
   count_type access_cnt_ff, access_cnt_in;
   count_type hit_cnt_ff, hit_cnt_in;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_hit_ff;
   way_type rsp_way_ff;

   logic        req_fire;
   logic        lookup_fire;
   logic        mem_we;
   set_type     req_set;
   tag_row_type row_eff;
   tag_row_type row_new;
   way_type     victim;
   match_type   match;

   assign req_set     = addr_set(req_address);
   assign lookup_fire = lookup_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !lookup_ff || lookup_fire;
   assign req_fire    = req_valid && req_ready;

   // Newest row of the set under compare: forwarded write-back or memory.
   assign row_eff = fwd_ff ? fwd_row_ff : rdata_ff;
   assign victim  = victim_ff[set_ff];

   sacl_match u_match (
      .row   (row_eff),
      .valid (valid_ff[set_ff]),
      .tag   (tag_ff),
      .match (match)
   );

   assign mem_we = lookup_fire && !match.hit;

   always_comb begin
      row_new         = row_eff;
      row_new[victim] = tag_ff;
   end

   // Next-state logic.
   always_comb begin
      valid_in      = valid_ff;
      victim_in     = victim_ff;
      access_cnt_in = access_cnt_ff;
      hit_cnt_in    = hit_cnt_ff;
      lookup_in     = lookup_ff;
      fwd_in        = fwd_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (lookup_fire) begin
         lookup_in    = 1'b0;
         rsp_valid_in = 1'b1;
         if (access_cnt_ff != '1) begin
            access_cnt_in = access_cnt_ff + 1'b1;
         end
         if (match.hit) begin
            if (hit_cnt_ff != '1) begin
               hit_cnt_in = hit_cnt_ff + 1'b1;
            end
         end else begin
            valid_in[set_ff][victim] = 1'b1;
            if (victim == way_type'(WAYS - 1)) begin
               victim_in[set_ff] = '0;
            end else begin
               victim_in[set_ff] = victim + 1'b1;
            end
         end
      end
      if (req_fire) begin
         lookup_in = 1'b1;
         fwd_in    = mem_we && (req_set == set_ff);
      end
   end

   // Tag memory: row write-back on a miss, registered read on acceptance.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[set_ff] <= row_new;
      end
      if (req_fire) begin
         rdata_ff <= tag_mem[req_set];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         set_ff     <= req_set;
         tag_ff     <= addr_tag(req_address);
         fwd_row_ff <= row_new;
      end
      if (lookup_fire) begin
         rsp_hit_ff <= match.hit;
         rsp_way_ff <= match.hit ? match.way : victim;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         victim_ff     <= '0;
         access_cnt_ff <= '0;
         hit_cnt_ff    <= '0;
         lookup_ff     <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         victim_ff     <= victim_in;
         access_cnt_ff <= access_cnt_in;
         hit_cnt_ff    <= hit_cnt_in;
         lookup_ff     <= lookup_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_way      = WAY_PORT_BITS'(rsp_way_ff);
   assign rsp_accesses = access_cnt_ff;
   assign rsp_hits     = hit_cnt_ff;

   // Hits can never outrun accesses.
   a_hits_le_accesses: assert property (@(posedge clock) disable iff (reset)
      hit_cnt_ff <= access_cnt_ff)
      else $error("hit count exceeds access count");

   // A finished compare always lands in the response register.
   a_lookup_to_rsp: assert property (@(posedge clock) disable iff (reset)
      lookup_fire |=> rsp_valid_ff && !lookup_ff || rsp_valid_ff && $past(req_fire))
      else $error("compare result lost");

   // A miss leaves the filled line valid.
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(set_ff)][$past(victim)])
      else $error("filled line not valid");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import sacl_pkg::*;

   // Result of one lookup, as seen on the rsp_ channel
   typedef struct packed {
      logic       hit;
      logic [1:0] way;
      count_type  accesses;
      count_type  hits;
   } lookup_result_type;

   // Directed stimulus row: pinned rows carry a hand-written expectation
   typedef struct packed {
      addr_type          addr;
      logic              pinned;
      lookup_result_type expect_res;
   } access_row_type;

   localparam int RANDOM_PER_PHASE = 185;
   localparam int HOLD_CYCLES      = 80;
   localparam int STALL_LIMIT      = 2000;
   localparam int DRAIN_CYCLES     = 8;
   localparam int TAG_POOL_SIZE    = 6;
   localparam int NUM_PHASES       = 4;
   localparam int NUM_DIRECTED     = 17;

   // Idle/stall percentages per phase: none, sender, receiver, both
   localparam int SEND_IDLE [NUM_PHASES] = '{0, 55, 0, 36};
   localparam int RECV_STALL[NUM_PHASES] = '{0, 0, 55, 36};

   // Set index = addr[9:7], tag = addr[31:10] at the default geometry
   access_row_type directed_rows[NUM_DIRECTED] = '{
      // cold miss right after reset lands in way 0
      '{32'h0000_0000, 1'b1, '{1'b0, 2'd0, 32'd1, 32'd0}},
      // same line, top offset: offset is ignored, so this hits
      '{32'h0000_007F, 1'b1, '{1'b1, 2'd0, 32'd2, 32'd1}},
      // all-ones address: last set, all-ones tag
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 2'd0, 32'd3, 32'd1}},
      '{32'hFFFF_FF80, 1'b1, '{1'b1, 2'd0, 32'd4, 32'd2}},
      // set 0 fills round robin: way 1, 2, 3, then wraps and evicts way 0
      '{32'h0000_0400, 1'b1, '{1'b0, 2'd1, 32'd5, 32'd2}},
      '{32'h0000_0800, 1'b0, '0},
      '{32'h0000_0C00, 1'b0, '0},
      '{32'h0000_1000, 1'b0, '0},
      // evicted tag comes back as a miss
      '{32'h0000_0000, 1'b0, '0},
      '{32'h0000_0C40, 1'b0, '0},
      '{32'h0000_0080, 1'b0, '0},
      '{32'h0000_0380, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'h8000_007F, 1'b0, '0},
      '{32'h0000_0555, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   addr_type   req_address = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_hit;
   logic [1:0] rsp_way;
   count_type  rsp_accesses;
   count_type  rsp_hits;

   set_assoc_cache_tag_lookup dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_address  (req_address),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hit      (rsp_hit),
      .rsp_way      (rsp_way),
      .rsp_accesses (rsp_accesses),
      .rsp_hits     (rsp_hits)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Tag store shadow: valid bits, tags, victim pointers, counters
   // ---------------------------------------------------------------------
   bit        shadow_valid[NUM_SETS][WAYS];
   tag_type   shadow_tag[NUM_SETS][WAYS];
   int        shadow_victim[NUM_SETS];
   count_type shadow_accesses = '0;
   count_type shadow_hits = '0;

   lookup_result_type pending_lookups[$];
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   // Driver-to-monitor sideband for the transaction currently offered
   logic              item_pinned = 1'b0;
   lookup_result_type item_expect = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_go = 1'b0;
   bit hold_off = 1'b0;

   tag_type tag_pool[TAG_POOL_SIZE];

   function automatic count_type bump_saturating(count_type value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   // Looks up one address in the shadow store and applies the fill on a miss
   function automatic lookup_result_type lookup_tags(addr_type addr);
      lookup_result_type res;
      int                set_idx;
      tag_type           tag;
      bit                found;
      int                way_idx;
      set_idx = int'((addr / LINE_BYTES) % NUM_SETS);
      tag     = tag_type'(addr / (LINE_BYTES * NUM_SETS));
      found   = 1'b0;
      way_idx = 0;
      shadow_accesses = bump_saturating(shadow_accesses);
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
            found   = 1'b1;
            way_idx = w;
         end
      end
      if (found) begin
         shadow_hits = bump_saturating(shadow_hits);
      end else begin
         // victim pointer alone decides; invalid ways get no preference
         way_idx = shadow_victim[set_idx];
         shadow_valid[set_idx][way_idx] = 1'b1;
         shadow_tag[set_idx][way_idx]   = tag;
         shadow_victim[set_idx]         = (way_idx + 1) % WAYS;
      end
      res.hit      = found;
      res.way      = 2'(way_idx);
      res.accesses = shadow_accesses;
      res.hits     = shadow_hits;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] seen);
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, seen);
      mismatch_count++;
   endtask

   task automatic check_result(input lookup_result_type seen,
                               input lookup_result_type want);
      if (seen.hit !== want.hit) report_mismatch("hit", 32'(want.hit), 32'(seen.hit));
      if (seen.way !== want.way) report_mismatch("way", 32'(want.way), 32'(seen.way));
      if (seen.accesses !== want.accesses)
         report_mismatch("accesses", want.accesses, seen.accesses);
      if (seen.hits !== want.hits) report_mismatch("hits", want.hits, seen.hits);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge, plus the watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         // response side first so a transaction accepted on this same edge
         // can never be matched against its own expectation
         if (rsp_valid && rsp_ready) begin
            if (pending_lookups.size() == 0)
               report_mismatch("unexpected response, accesses", '0, rsp_accesses);
            else
               check_result({rsp_hit, rsp_way, rsp_accesses, rsp_hits},
                            pending_lookups.pop_front());
         end
         if (req_valid && req_ready) begin
            if (item_pinned) begin
               // keep the shadow in step; the typed row is what gets checked
               void'(lookup_tags(req_address));
               pending_lookups.push_back(item_expect);
            end else begin
               pending_lookups.push_back(lookup_tags(req_address));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random backpressure, plus one long hold-off
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset)
         rsp_ready = 1'b0;
      else
         rsp_ready = !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Long stall counted here while the driver keeps offering, so the
   // pipeline fills and req_ready has to drop
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Called at a falling edge; returns at the falling edge after acceptance.
   // valid stays high across back-to-back transactions.
   task automatic offer_access(input addr_type addr, input logic pinned,
                               input lookup_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_address = addr;
      item_pinned = pinned;
      item_expect = want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_lookups.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly tags from a small per-phase pool so sets see hits, refills and
   // evictions; the rest are raw 32-bit addresses to toggle every bit
   function automatic addr_type pick_address();
      tag_type tag;
      if ($urandom_range(99) < 15) return addr_type'($urandom);
      tag = tag_pool[$urandom_range(TAG_POOL_SIZE - 1)];
      return addr_type'(tag) * (LINE_BYTES * NUM_SETS)
           + addr_type'($urandom_range(NUM_SETS - 1)) * LINE_BYTES
           + addr_type'($urandom_range(LINE_BYTES - 1));
   endfunction

   initial begin
      for (int s = 0; s < NUM_SETS; s++) begin
         shadow_victim[s] = 0;
         for (int w = 0; w < WAYS; w++) begin
            shadow_valid[s][w] = 1'b0;
            shadow_tag[s][w]   = '0;
         end
      end

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // directed part, no idling on either side
      for (int r = 0; r < NUM_DIRECTED; r++)
         offer_access(directed_rows[r].addr, directed_rows[r].pinned,
                      directed_rows[r].expect_res);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct  = SEND_IDLE[phase];
         recv_stall_pct = RECV_STALL[phase];
         for (int p = 0; p < TAG_POOL_SIZE; p++) tag_pool[p] = tag_type'($urandom);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 0 && n == 60) hold_go = 1'b1;
            offer_access(pick_address(), 1'b0, '0);
         end
         // sender goes quiet until every response of the phase is back
         req_valid = 1'b0;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
